@@ rtl/bwfa_pkg.sv @@
// Shared definitions for the best/worst fit page allocator.
// Holds the field widths, operation and status codes and the controller interface types.
// No dependencies.
`default_nettype none

package bwfa_pkg;

	// Default sizes. The top level hands these down as parameters.
	localparam int NUM_PAGES_DEF = 32;
	localparam int ID_BITS_DEF   = 8;

	// Fixed field widths of the request and result words.
	localparam int SIZE_W   = 10;
	localparam int STATUS_W = 2;
	localparam int START_W  = 5;
	localparam int COUNT_W  = 6;
	localparam int HOLES_W  = 5;

	// Pages are 4 KB, so a size in KB is rounded up and shifted down by two.
	localparam int KB_PER_PAGE = 4;
	localparam int PAGE_SHIFT  = 2;
	localparam int NEED_W      = SIZE_W + 1 - PAGE_SHIFT;

	// Operation codes. The spare code behaves as a fragment query.
	localparam logic [1:0] ACT_ADD   = 2'd0;
	localparam logic [1:0] ACT_KILL  = 2'd1;
	localparam logic [1:0] ACT_COUNT = 2'd2;
	localparam logic [1:0] ACT_SPARE = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_MEM    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ZERO      = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture the request word and clear the scan state
		logic quick;    // answer at once, no page scan needed
		logic scan_en;  // step the page scan by one entry
		logic apply;    // update the page tables and register the result
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic needs_scan; // the word on the request ports needs a page scan
		logic scan_done;  // the end-of-table entry is being processed
	} dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/bwfa_ctrl.sv @@
// Controller state machine of the page allocator.
// Sequences load, page scan and table update; depends on bwfa_pkg.
`default_nettype none

module bwfa_ctrl import bwfa_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire dp_stat_t  stat,
	output      ctrl_cmd_t cmd,
	output      logic      busy
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_APPLY = 3'b100
	} state_t;

	state_t state_q, state_nx;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (stat.needs_scan) begin
						state_nx = S_SCAN;
					end else begin
						cmd.quick = 1'b1;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_en = 1'b1;
				if (stat.scan_done) begin
					state_nx = S_APPLY;
				end
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_nx  = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/bwfa_dp.sv @@
// Datapath of the page allocator: page tables, owner memory, scan registers and result word.
// Driven by bwfa_ctrl through ctrl_cmd_t; depends on bwfa_pkg.
`default_nettype none

module bwfa_dp import bwfa_pkg::*; #(
	parameter int NUM_PAGES = NUM_PAGES_DEF,
	parameter int ID_BITS   = ID_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ctrl_cmd_t           cmd,
	output      dp_stat_t            stat,
	input  wire logic [1:0]          action,
	input  wire logic [ID_BITS-1:0]  program_id,
	input  wire logic [SIZE_W-1:0]   size_kb,
	input  wire logic                cfg_we,
	input  wire logic                cfg_data,
	output      logic                done,
	output      logic [STATUS_W-1:0] status,
	output      logic [START_W-1:0]  start_page,
	output      logic [COUNT_W-1:0]  page_count,
	output      logic [HOLES_W-1:0]  hole_count
);

	localparam int AW = $clog2(NUM_PAGES);
	localparam int CW = $clog2(NUM_PAGES + 1);
	localparam int PW = $clog2(NUM_PAGES + 3);
	localparam int HW = $clog2((NUM_PAGES + 1) / 2 + 1);
	localparam int LW = (CW > NEED_W) ? CW : NEED_W;

	// Page tables and owner store.
	logic [NUM_PAGES-1:0] in_use_q, head_q;
	logic [ID_BITS-1:0]   owner_mem [NUM_PAGES];
	logic                 fit_mode_q;
	logic [HW-1:0]        holes_q;

	// Captured request.
	logic                 is_kill_q;
	logic [ID_BITS-1:0]   id_q;
	logic [NEED_W-1:0]    need_q;

	// Scan pointer and the entry under inspection.
	logic [PW-1:0]        ptr_q, ptr_s1;
	logic                 vld_s1;
	logic [ID_BITS-1:0]   owner_s1;

	// Hole search and owner search state.
	logic [CW-1:0]        run_len_q, best_len_q, kill_end_q;
	logic [AW-1:0]        run_start_q, best_start_q, kill_start_q;
	logic                 fit_found_q, kill_found_q, end_found_q;

	// Result word.
	logic                 done_q;
	logic [STATUS_W-1:0]  status_q;
	logic [START_W-1:0]   start_q;
	logic [COUNT_W-1:0]   count_q;
	logic [HOLES_W-1:0]   holes_out_q;

	logic [SIZE_W:0]      size_round;
	logic [NEED_W-1:0]    need_in;
	logic                 at_end, elem_used, elem_free, elem_head, run_fits, run_better;
	logic [AW-1:0]        idx_s1;
	logic                 add_ok, op_ok, left_free, right_free, mem_we;
	logic [AW-1:0]        rng_lo;
	logic [LW:0]          rng_hi;
	logic [NUM_PAGES-1:0] in_use_nx, head_nx;
	logic [HW-1:0]        holes_nx;

	// Pages needed: size rounded up to whole pages.
	assign size_round = {1'b0, size_kb} + (SIZE_W + 1)'(KB_PER_PAGE - 1);
	assign need_in    = NEED_W'(size_round >> PAGE_SHIFT);

	assign stat.needs_scan = ((action == ACT_ADD) && (size_kb != '0)) || (action == ACT_KILL);

	assign at_end    = (ptr_s1 == PW'(NUM_PAGES));
	assign idx_s1    = ptr_s1[AW-1:0];
	assign elem_used = !at_end && in_use_q[idx_s1];
	assign elem_free = !at_end && !in_use_q[idx_s1];
	assign elem_head = head_q[idx_s1];
	assign stat.scan_done = vld_s1 && at_end;

	// A closing run replaces the current choice when it is strictly better, so ties keep the
	// lowest hole. Worst fit takes the largest run whatever its size and checks it at the end.
	assign run_fits   = LW'(run_len_q) >= LW'(need_q);
	assign run_better = fit_mode_q ? (!fit_found_q || (run_len_q > best_len_q)) :
	                    (run_fits && (!fit_found_q || (run_len_q < best_len_q)));

	assign add_ok = fit_found_q && (LW'(best_len_q) >= LW'(need_q));
	assign op_ok  = is_kill_q ? kill_found_q : add_ok;
	assign mem_we = cmd.apply && !is_kill_q && add_ok;

	assign rng_lo = is_kill_q ? kill_start_q : best_start_q;
	assign rng_hi = is_kill_q ? (LW + 1)'(kill_end_q) :
	                (LW + 1)'(best_start_q) + (LW + 1)'(need_q);

	always_comb begin
		for (int i = 0; i < NUM_PAGES; i++) begin
			if ((AW'(i) >= rng_lo) && ((LW + 1)'(i) < rng_hi)) begin
				in_use_nx[i] = !is_kill_q;
				head_nx[i]   = !is_kill_q && (AW'(i) == rng_lo);
			end else begin
				in_use_nx[i] = in_use_q[i];
				head_nx[i]   = head_q[i];
			end
		end
	end

	// A freed range adds one hole, less one for each free neighbour it joins. An allocation
	// removes its hole only when it fills it exactly.
	assign left_free  = (kill_start_q != '0) && !in_use_q[kill_start_q - AW'(1)];
	assign right_free = (kill_end_q < CW'(NUM_PAGES)) && !in_use_q[kill_end_q[AW-1:0]];
	assign holes_nx   = is_kill_q ?
	                    (holes_q + HW'(1) - HW'(left_free) - HW'(right_free)) :
	                    (holes_q - HW'(LW'(best_len_q) == LW'(need_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q     <= '0;
			head_q       <= '0;
			holes_q      <= HW'(1);
			fit_mode_q   <= 1'b0;
			ptr_q        <= '0;
			vld_s1       <= 1'b0;
			fit_found_q  <= 1'b0;
			kill_found_q <= 1'b0;
			end_found_q  <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= cmd.quick | cmd.apply;
			if (cfg_we) begin
				fit_mode_q <= cfg_data;
			end
			if (cmd.load) begin
				ptr_q        <= '0;
				vld_s1       <= 1'b0;
				fit_found_q  <= 1'b0;
				kill_found_q <= 1'b0;
				end_found_q  <= 1'b0;
			end else if (cmd.scan_en) begin
				ptr_q  <= ptr_q + PW'(1);
				vld_s1 <= 1'b1;
				if (vld_s1) begin
					if (!is_kill_q) begin
						if (!elem_free && (run_len_q != '0) && run_better) begin
							fit_found_q <= 1'b1;
						end
					end else if (!kill_found_q) begin
						if (elem_used && elem_head && (owner_s1 == id_q)) begin
							kill_found_q <= 1'b1;
						end
					end else if (!end_found_q) begin
						if (at_end || !elem_used || elem_head) begin
							end_found_q <= 1'b1;
						end
					end
				end
			end
			if (cmd.apply && op_ok) begin
				in_use_q <= in_use_nx;
				head_q   <= head_nx;
				holes_q  <= holes_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_kill_q <= (action == ACT_KILL);
			id_q      <= program_id;
			need_q    <= need_in;
			run_len_q <= '0;
		end else if (cmd.scan_en) begin
			ptr_s1 <= ptr_q;
			if (vld_s1) begin
				if (!is_kill_q) begin
					if (elem_free) begin
						if (run_len_q == '0) begin
							run_start_q <= idx_s1;
						end
						run_len_q <= run_len_q + CW'(1);
					end else begin
						if ((run_len_q != '0) && run_better) begin
							best_start_q <= run_start_q;
							best_len_q   <= run_len_q;
						end
						run_len_q <= '0;
					end
				end else if (!kill_found_q) begin
					kill_start_q <= idx_s1;
				end else if (!end_found_q) begin
					kill_end_q <= CW'(ptr_s1);
				end
			end
		end
	end

	// Owner store: one registered read a scan step, one write at the head of a new allocation.
	always_ff @(posedge clk) begin
		if (cmd.scan_en) begin
			owner_s1 <= owner_mem[ptr_q[AW-1:0]];
		end
		if (mem_we) begin
			owner_mem[best_start_q] <= id_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.quick) begin
			status_q    <= (action == ACT_ADD) ? ST_ZERO : ST_OK;
			start_q     <= '0;
			count_q     <= '0;
			holes_out_q <= HOLES_W'(holes_q);
		end else if (cmd.apply) begin
			if (op_ok) begin
				status_q    <= ST_OK;
				start_q     <= START_W'(rng_lo);
				count_q     <= is_kill_q ? COUNT_W'(kill_end_q - CW'(kill_start_q)) :
				               COUNT_W'(need_q);
				holes_out_q <= HOLES_W'(holes_nx);
			end else begin
				status_q    <= is_kill_q ? ST_NOT_FOUND : ST_NO_MEM;
				start_q     <= '0;
				count_q     <= '0;
				holes_out_q <= HOLES_W'(holes_q);
			end
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign start_page = start_q;
	assign page_count = count_q;
	assign hole_count = holes_out_q;

endmodule

`default_nettype wire

@@ rtl/best_worst_fit_page_allocator.sv @@
// Add and kill take one pass over the page table, with one owner-memory read a cycle,
// and then a single table update before the result word. Busy stays high through the scan
// and the update, so no new such word is taken until the current one has finished.
// Queries and zero-size adds answer in the next cycle, one per cycle while busy is low.
// Reset frees every page, clears the allocation marks and selects best fit; the owner memory
// is not cleared. Results carry a one-cycle strobe and the receiver cannot stall them.
`default_nettype none

module best_worst_fit_page_allocator import bwfa_pkg::*; #(
	parameter int NUM_PAGES = NUM_PAGES_DEF,
	parameter int ID_BITS   = ID_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// Request channel: a word is taken when start is high and busy is low.
	input  wire logic                start,
	output      logic                busy,
	input  wire logic [1:0]          action,
	input  wire logic [ID_BITS-1:0]  program_id,
	input  wire logic [SIZE_W-1:0]   size_kb,
	// Fit mode register write channel.
	input  wire logic                cfg_valid,
	output      logic                cfg_ready,
	input  wire logic                cfg_data,
	// Result channel: one word for every request, shown for exactly one cycle.
	output      logic                done,
	output      logic [STATUS_W-1:0] status,
	output      logic [START_W-1:0]  start_page,
	output      logic [COUNT_W-1:0]  page_count,
	output      logic [HOLES_W-1:0]  hole_count
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	logic      cfg_we;

	// The fit mode may only change between operations, so the write channel is held off
	// while an operation is in progress.
	assign cfg_ready = !busy;
	assign cfg_we    = cfg_valid && cfg_ready;

	// The controller decides whether a request needs the page scan, runs the scan for one
	// pass over every page plus the end-of-table entry, and then fires a single update.
	bwfa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath holds the page tables, the owner memory, the hole counter and the result
	// register. The hole count is kept up to date incrementally, so every result word can
	// report it without a second pass over the table.
	bwfa_dp #(
		.NUM_PAGES (NUM_PAGES),
		.ID_BITS   (ID_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.action     (action),
		.program_id (program_id),
		.size_kb    (size_kb),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.done       (done),
		.status     (status),
		.start_page (start_page),
		.page_count (page_count),
		.hole_count (hole_count)
	);

endmodule

`default_nettype wire

@@ rtl/bwfa_chk.sv @@
// Port-level checker for the page allocator, bound to the top level.
// Depends on bwfa_pkg and on best_worst_fit_page_allocator.
`default_nettype none

module bwfa_chk import bwfa_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire logic [1:0]          action,
	input wire logic [SIZE_W-1:0]   size_kb,
	input wire logic                done,
	input wire logic [STATUS_W-1:0] status,
	input wire logic [START_W-1:0]  start_page,
	input wire logic [COUNT_W-1:0]  page_count
);

	// A result word only appears once the block is free again.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// A kill always needs the page scan.
	a_kill_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action == ACT_KILL)) |=> busy)
		else $error("kill did not start a scan");

	// A fragment query answers in the next cycle with success.
	a_query_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && ((action == ACT_COUNT) || (action == ACT_SPARE)))
		|=> (done && (status == ST_OK) && (page_count == '0)))
		else $error("fragment query not answered at once");

	// A zero-size add is rejected in the next cycle.
	a_zero_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action == ACT_ADD) && (size_kb == '0))
		|=> (done && (status == ST_ZERO)))
		else $error("zero-size add not rejected");

	// Every error word carries zero start page and page count.
	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> ((start_page == '0) && (page_count == '0)))
		else $error("error word with non-zero fields");

endmodule

bind best_worst_fit_page_allocator bwfa_chk u_bwfa_chk (.*);

`default_nettype wire
